// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

    // Field widths fixed by the item format.
    localparam int VALUE_W         = 32;
    localparam int PRIO_W          = 32;
    localparam int COUNT_FIELD_W   = 5;
    localparam int DEF_QUEUE_DEPTH = 16;

    // Operation selector carried on the input side.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_mode_t;

    // Status reported with every result.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } op_status_t;

    // One stored queue entry.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } entry_t;

    // Per-cell control broadcast from the top level.
    typedef struct packed {
        logic do_insert;
        logic do_remove;
        logic occupied;
        logic at_tail;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  entry_t     left_entry,
    input  logic       left_greater,
    input  entry_t     right_entry,
    output entry_t     entry,
    output logic       greater
);

    entry_t entry_reg;
    entry_t entry_next;

    // The new entry outranks this cell when its priority is strictly higher.
    assign greater = ctrl.occupied && (new_entry.prio > entry_reg.prio);

    // Shift right on insert past this cell, take the new entry at the
    // insertion point, shift left on remove, otherwise hold.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.do_remove)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.do_insert)
        begin
            priority if (left_greater)
            begin
                entry_next = left_entry;
            end
            else if (greater || ctrl.at_tail)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Sorted priority queue built as a chain of compare-and-shift cells.
// An accepted transaction's result is registered and presented on the next cycle.
// One insert or remove per cycle unless the result stalls; every cell decides
// in parallel against the broadcast entry and its left neighbor, so no
// operation iterates. Reset clears the entry count and the pending result;
// cell contents are not cleared and are only read below the entry count.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // item_value [31:0], item_priority [63:32]
    input  logic [0:0]  s_tuser,   // mode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // head_value [31:0], head_priority [63:32],
                                   // is_empty [64], entry_count [69:65],
                                   // op_status [71:70]
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    op_status_t    status_reg;
    op_status_t    status_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    logic          accept;
    op_mode_t      mode;
    logic          full;
    logic          empty;
    logic          do_insert;
    logic          do_remove;
    entry_t        new_entry;

    entry_t        cell_entry   [QUEUE_DEPTH];
    logic          cell_greater [QUEUE_DEPTH];

    // Input decode.
    assign accept          = s_tvalid && s_tready;
    assign mode            = op_mode_t'(s_tuser[0]);
    assign new_entry.value = s_tdata[31:0];
    assign new_entry.prio  = s_tdata[63:32];
    assign full            = (count_reg == CW'(QUEUE_DEPTH));
    assign empty           = (count_reg == '0);
    assign do_insert       = accept && (mode == OP_INSERT) && !full;
    assign do_remove       = accept && (mode == OP_REMOVE) && !empty;

    // A new transaction is taken while the result register is free or drains.
    assign s_tready = !out_valid_reg || m_tready;

    // Cell chain.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        entry_t     left_entry;
        logic       left_greater;
        entry_t     right_entry;

        assign ctrl.do_insert = do_insert;
        assign ctrl.do_remove = do_remove;
        assign ctrl.occupied  = (CW'(i) < count_reg);
        assign ctrl.at_tail   = (CW'(i) == count_reg);

        if (i == 0)
        begin : g_first
            assign left_entry   = new_entry;
            assign left_greater = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry   = cell_entry[i-1];
            assign left_greater = cell_greater[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .new_entry    (new_entry),
            .left_entry   (left_entry),
            .left_greater (left_greater),
            .right_entry  (right_entry),
            .entry        (cell_entry[i]),
            .greater      (cell_greater[i])
        );
    end

    // Count, status and result-valid update.
    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            unique case (mode)
                OP_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result formed from the head cell and the count; both hold while stalled.
    assign m_tvalid       = out_valid_reg;
    assign m_tdata[31:0]  = empty ? '0 : cell_entry[0].value;
    assign m_tdata[63:32] = empty ? '0 : cell_entry[0].prio;
    assign m_tdata[64]    = empty;
    assign m_tdata[69:65] = COUNT_FIELD_W'(count_reg);
    assign m_tdata[71:70] = status_reg;

    // The count never exceeds the number of cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

    // An overflow is only reported with a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_OVERFLOW) |-> full)
    else $error("overflow reported while not full");

    // An underflow is only reported with an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_UNDERFLOW) |-> empty)
    else $error("underflow reported while not empty");

    // A successful insert grows the count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> (count_reg == $past(count_reg) + CW'(1)))
    else $error("insert did not grow the count by one");

endmodule
